// ===== rtl/rletex_pkg.sv =====
package rletex_pkg;

    // Pixel count of one texture.
    localparam int IMAGE_PIXELS = 16384;

    localparam int WORD_W  = 16;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 15;
    localparam int PE_W    = $clog2(IMAGE_PIXELS + 1);
    localparam int LIT_W   = 9;

    localparam logic [WORD_W-1:0] LITERAL_MARK = 16'hFF00;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Widen one 5-bit colour field to 8 bits (times 8).
    function automatic chan_t expand5(input logic [4:0] field);
        expand5 = {field, 3'b000};
    endfunction

endpackage

// ===== rtl/rle_rgb555_texture_decoder_top.sv =====
// Run-length RGB555 texture decoder. Takes one 16-bit texture stream word per
// item on the in channel and gives at most one pixel run per item on the out
// channel: 8-bit red, green and blue (each 5-bit field times 8, bit 15
// dropped), the number of consecutive pixels in that colour and a flag on the
// result that completes the texture. With compressed_mode at 1 (reset value)
// the two size words are skipped, a count word with high byte FF opens a run
// of (65536 - count) literal words and any other count word repeats the next
// word that many times; a count of zero gives nothing. Runs are clipped at
// IMAGE_PIXELS (rletex_pkg); literal words past the end are swallowed, and the
// decoder restarts for the next texture once the image is complete. With
// compressed_mode at 0 every word is one pixel. Each item is decoded in the
// cycle it is accepted and the result lands in the output register, so the
// block takes one item per cycle; in_ready drops only while that output
// register holds a result the consumer has not taken. Write compressed_mode
// through the cfg channel only while the decoder is idle; cfg_ready is always
// high.
module rle_rgb555_texture_decoder_top (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  rletex_pkg::word_t      word,

    output logic                   out_valid,
    input  logic                   out_ready,
    output rletex_pkg::chan_t      red,
    output rletex_pkg::chan_t      green,
    output rletex_pkg::chan_t      blue,
    output rletex_pkg::count_t     repeat_count,
    output logic                   image_done
);

    import rletex_pkg::*;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_COUNT,
        PH_LITERAL,
        PH_REPEAT
    } phase_t;

    localparam logic [PE_W-1:0] IMAGE_END = PE_W'(IMAGE_PIXELS);

    // Decoder state
    logic               compressed_mode_reg;
    phase_t             phase_reg, phase_next;
    logic               skipped_reg, skipped_next;
    logic [LIT_W-1:0]   literal_left_reg, literal_left_next;
    word_t              held_repeat_reg, held_repeat_next;
    logic [PE_W-1:0]    pixels_emitted_reg, pixels_emitted_next;

    // Output register
    logic               out_valid_reg;
    chan_t              red_reg, green_reg, blue_reg;
    count_t             repeat_count_reg;
    logic               image_done_reg;

    // Result of the item in the input slot
    logic               res_valid;
    count_t             res_count;
    logic               res_done;

    logic               in_accept;

    // Scratch for the decode
    logic [PE_W-1:0]    pe_base;
    logic [PE_W-1:0]    pe_inc;
    logic [LIT_W-1:0]   lit_dec;
    logic [PE_W-1:0]    pix_left;
    logic [PE_W-1:0]    run_len;
    logic [PE_W-1:0]    pe_sum;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // Decode one word against the current state.
    always_comb
    begin
        phase_next          = phase_reg;
        skipped_next        = skipped_reg;
        literal_left_next   = literal_left_reg;
        held_repeat_next    = held_repeat_reg;
        pixels_emitted_next = pixels_emitted_reg;
        res_valid           = 1'b0;
        res_count           = COUNT_W'(1);
        res_done            = 1'b0;

        pe_base  = (pixels_emitted_reg >= IMAGE_END) ? '0 : pixels_emitted_reg;
        pe_inc   = pe_base + PE_W'(1);
        lit_dec  = (literal_left_reg != '0) ? literal_left_reg - LIT_W'(1) : '0;
        pix_left = (pixels_emitted_reg < IMAGE_END) ? IMAGE_END - pixels_emitted_reg : '0;
        run_len  = ({1'b0, held_repeat_reg} < (WORD_W + 1)'(pix_left))
                   ? PE_W'(held_repeat_reg) : pix_left;
        pe_sum   = pixels_emitted_reg + run_len;

        if (!compressed_mode_reg)
        begin
            // Raw words: one pixel each; a finished image restarts first.
            if (pixels_emitted_reg >= IMAGE_END)
            begin
                phase_next        = PH_SKIP;
                skipped_next      = 1'b0;
                literal_left_next = '0;
                held_repeat_next  = '0;
            end
            res_valid = 1'b1;
            if (pe_inc >= IMAGE_END)
            begin
                res_done            = 1'b1;
                phase_next          = PH_SKIP;
                skipped_next        = 1'b0;
                literal_left_next   = '0;
                held_repeat_next    = '0;
                pixels_emitted_next = '0;
            end
            else
            begin
                pixels_emitted_next = pe_inc;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (skipped_reg)
                    begin
                        skipped_next = 1'b0;
                        phase_next   = PH_COUNT;
                    end
                    else
                    begin
                        skipped_next = 1'b1;
                    end
                end
                PH_COUNT:
                begin
                    if ((word & LITERAL_MARK) == LITERAL_MARK)
                    begin
                        literal_left_next = LIT_W'((WORD_W + 1)'(1 << WORD_W) - {1'b0, word});
                        phase_next        = PH_LITERAL;
                    end
                    else
                    begin
                        held_repeat_next = word;
                        phase_next       = PH_REPEAT;
                    end
                end
                PH_LITERAL:
                begin
                    literal_left_next = lit_dec;
                    if (pixels_emitted_reg < IMAGE_END)
                    begin
                        pixels_emitted_next = pixels_emitted_reg + PE_W'(1);
                        res_valid           = 1'b1;
                        res_done            = (pixels_emitted_reg + PE_W'(1)) >= IMAGE_END;
                    end
                    if (lit_dec == '0)
                    begin
                        if (pixels_emitted_next >= IMAGE_END)
                        begin
                            phase_next          = PH_SKIP;
                            skipped_next        = 1'b0;
                            literal_left_next   = '0;
                            held_repeat_next    = '0;
                            pixels_emitted_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_COUNT;
                        end
                    end
                end
                PH_REPEAT:
                begin
                    held_repeat_next = '0;
                    phase_next       = PH_COUNT;
                    res_count        = COUNT_W'(run_len);
                    if (run_len != '0)
                    begin
                        res_valid           = 1'b1;
                        pixels_emitted_next = pe_sum;
                        if (pe_sum >= IMAGE_END)
                        begin
                            res_done            = 1'b1;
                            phase_next          = PH_SKIP;
                            skipped_next        = 1'b0;
                            literal_left_next   = '0;
                            pixels_emitted_next = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    // State, configuration and the output register; load the payload only
    // when a new result is produced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_mode_reg <= 1'b1;
            phase_reg           <= PH_SKIP;
            skipped_reg         <= 1'b0;
            literal_left_reg    <= '0;
            held_repeat_reg     <= '0;
            pixels_emitted_reg  <= '0;
            out_valid_reg       <= 1'b0;
            red_reg             <= '0;
            green_reg           <= '0;
            blue_reg            <= '0;
            repeat_count_reg    <= '0;
            image_done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                compressed_mode_reg <= cfg_data;
            end
            if (in_accept)
            begin
                phase_reg          <= phase_next;
                skipped_reg        <= skipped_next;
                literal_left_reg   <= literal_left_next;
                held_repeat_reg    <= held_repeat_next;
                pixels_emitted_reg <= pixels_emitted_next;
                out_valid_reg      <= res_valid;
                if (res_valid)
                begin
                    red_reg          <= expand5(word[4:0]);
                    green_reg        <= expand5(word[9:5]);
                    blue_reg         <= expand5(word[14:10]);
                    repeat_count_reg <= res_count;
                    image_done_reg   <= res_done;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign repeat_count = repeat_count_reg;
    assign image_done   = image_done_reg;

    // The pixel count never passes the image end.
    a_pixels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pixels_emitted_reg <= IMAGE_END)
        else $error("pixel count beyond image end");

    // A result always covers at least one pixel.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (repeat_count_reg != '0))
        else $error("result with zero repeat count");

    // Inside a literal run there is always a word left to take.
    a_literal_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LITERAL) |-> (literal_left_reg != '0))
        else $error("literal phase with empty run");

    // Every raw word gives a result in the next cycle.
    a_raw_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !compressed_mode_reg) |=> out_valid_reg)
        else $error("raw word gave no result");

    // Completion resets the pixel count unless a clipped literal run drains.
    a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && res_valid && res_done && phase_reg != PH_LITERAL)
        |=> (pixels_emitted_reg == '0))
        else $error("image done without restart");

endmodule
